/* design/utf8d_pkg.sv */
// Shared types and constants for the UTF-8 checked decoder.
// No dependencies; used by the front, queue, back and top level.
package utf8d_pkg;

    localparam logic [7:0]  QMARK      = 8'h3F;
    localparam logic [7:0]  ASCII_MAX  = 8'h7F;
    localparam logic [7:0]  LEAD2_END  = 8'hE0;
    localparam logic [7:0]  LEAD3_END  = 8'hF0;
    localparam logic [7:0]  LEAD4_END  = 8'hF8;
    localparam logic [7:0]  LEAD_BAD   = 8'hFC;
    localparam logic [1:0]  CONT_TAG   = 2'b10;

    localparam logic [25:0] MIN2_LIM   = 26'h000007F;
    localparam logic [25:0] MIN3_LIM   = 26'h00007FF;
    localparam logic [25:0] MIN4_LIM   = 26'h000FFFF;
    localparam logic [25:0] MIN5_LIM   = 26'h01FFFFF;
    localparam logic [25:0] MAX5_LIM   = 26'h1000000;

    localparam logic [2:0]  LEN1       = 3'd1;
    localparam logic [2:0]  LEN2       = 3'd2;
    localparam logic [2:0]  LEN3       = 3'd3;
    localparam logic [2:0]  LEN4       = 3'd4;
    localparam logic [2:0]  LEN5       = 3'd5;

    // One input byte's worth of results: err_cnt '?' items, then an optional tail.
    typedef struct packed {
        logic [2:0]  err_cnt;
        logic        tail;
        logic [23:0] tail_cp;
        logic [2:0]  tail_len;
        logic        tail_bad;
        logic        last;
    } run_t;

endpackage

/* design/utf8d_front.sv */
// Front end: accepts bytes, tracks the open sequence and classifies each byte
// into a run descriptor. Depends on utf8d_pkg.
module utf8d_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      data_byte,
    input  logic            last_byte,
    input  logic            full,
    output logic            push,
    output utf8d_pkg::run_t push_item
);

    logic [2:0]  exp_len_reg, exp_len_next;
    logic [2:0]  held_reg, held_next;
    logic [25:0] part_reg, part_next;

    logic        accept;
    logic        is_cont;
    logic        f_tail, f_bad, f_open;
    logic [23:0] f_cp;
    logic [2:0]  f_len;
    logic [25:0] f_part;
    logic [2:0]  held_inc;
    logic [25:0] part_shift;
    logic        value_ok;
    utf8d_pkg::run_t item;

    assign accept   = in_valid && !full;
    assign in_stall = full;
    assign is_cont  = (data_byte[7:6] == utf8d_pkg::CONT_TAG);
    assign held_inc = held_reg + 3'd1;
    assign part_shift = {part_reg[19:0], data_byte[5:0]};

    // Decode of a byte that starts fresh: no sequence open, or the open one interrupted
    always_comb
    begin
        f_tail = 1'b0;
        f_bad  = 1'b0;
        f_open = 1'b0;
        f_cp   = {16'd0, utf8d_pkg::QMARK};
        f_len  = utf8d_pkg::LEN1;
        f_part = '0;
        if (data_byte <= utf8d_pkg::ASCII_MAX)
        begin
            f_tail = 1'b1;
            f_cp   = {16'd0, data_byte};
        end
        else if (is_cont || data_byte >= utf8d_pkg::LEAD_BAD)
        begin
            f_tail = 1'b1;
            f_bad  = 1'b1;
        end
        else
        begin
            if (data_byte < utf8d_pkg::LEAD2_END)
            begin
                f_len  = utf8d_pkg::LEN2;
                f_part = {21'd0, data_byte[4:0]};
            end
            else if (data_byte < utf8d_pkg::LEAD3_END)
            begin
                f_len  = utf8d_pkg::LEN3;
                f_part = {22'd0, data_byte[3:0]};
            end
            else if (data_byte < utf8d_pkg::LEAD4_END)
            begin
                f_len  = utf8d_pkg::LEN4;
                f_part = {23'd0, data_byte[2:0]};
            end
            else
            begin
                f_len  = utf8d_pkg::LEN5;
                f_part = {24'd0, data_byte[1:0]};
            end
            if (last_byte)
            begin
                f_tail = 1'b1;
                f_bad  = 1'b1;
            end
            else
            begin
                f_open = 1'b1;
            end
        end
    end

    always_comb
    begin
        unique case (exp_len_reg)
            utf8d_pkg::LEN2: value_ok = part_shift > utf8d_pkg::MIN2_LIM;
            utf8d_pkg::LEN3: value_ok = part_shift > utf8d_pkg::MIN3_LIM;
            utf8d_pkg::LEN4: value_ok = part_shift > utf8d_pkg::MIN4_LIM;
            utf8d_pkg::LEN5: value_ok = part_shift > utf8d_pkg::MIN5_LIM
                                     && part_shift < utf8d_pkg::MAX5_LIM;
            default:         value_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        item.err_cnt  = 3'd0;
        item.tail     = 1'b0;
        item.tail_cp  = {16'd0, utf8d_pkg::QMARK};
        item.tail_len = utf8d_pkg::LEN1;
        item.tail_bad = 1'b1;
        item.last     = last_byte;
        exp_len_next  = exp_len_reg;
        held_next     = held_reg;
        part_next     = part_reg;

        if (exp_len_reg != 3'd0 && is_cont)
        begin
            if (held_inc >= exp_len_reg)
            begin
                if (value_ok)
                begin
                    item.tail     = 1'b1;
                    item.tail_cp  = part_shift[23:0];
                    item.tail_len = exp_len_reg;
                    item.tail_bad = 1'b0;
                end
                else
                begin
                    item.err_cnt = exp_len_reg;
                end
                exp_len_next = 3'd0;
                held_next    = 3'd0;
                part_next    = '0;
            end
            else if (last_byte)
            begin
                item.err_cnt = held_inc;
                exp_len_next = 3'd0;
                held_next    = 3'd0;
                part_next    = '0;
            end
            else
            begin
                held_next = held_inc;
                part_next = part_shift;
            end
        end
        else
        begin
            // held bytes of an interrupted sequence go out first, then the fresh byte
            item.err_cnt  = (exp_len_reg != 3'd0) ? held_reg : 3'd0;
            item.tail     = f_tail;
            item.tail_cp  = f_cp;
            item.tail_len = utf8d_pkg::LEN1;
            item.tail_bad = f_bad;
            if (f_open)
            begin
                exp_len_next = f_len;
                held_next    = 3'd1;
                part_next    = f_part;
            end
            else
            begin
                exp_len_next = 3'd0;
                held_next    = 3'd0;
                part_next    = '0;
            end
        end
    end

    assign push      = accept && (item.tail || item.err_cnt != 3'd0);
    assign push_item = item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_len_reg <= 3'd0;
            held_reg    <= 3'd0;
            part_reg    <= '0;
        end
        else if (accept)
        begin
            exp_len_reg <= exp_len_next;
            held_reg    <= held_next;
            part_reg    <= part_next;
        end
    end

endmodule

/* design/utf8d_queue.sv */
// Short queue of run descriptors between front and back.
// Depends on utf8d_pkg.
module utf8d_queue #(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  utf8d_pkg::run_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output utf8d_pkg::run_t head_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    utf8d_pkg::run_t      slot_reg [DEPTH];
    logic [PW-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]        cnt_reg, cnt_next;

    assign full       = (cnt_reg == CW'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

endmodule

/* design/utf8d_back.sv */
// Back end: expands each run descriptor into result items, one per cycle
// while out_stall is low, into an output register. Depends on utf8d_pkg.
module utf8d_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  utf8d_pkg::run_t head_item,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [23:0]     code_point,
    output logic [2:0]      byte_length,
    output logic            malformed,
    output logic            end_of_run,
    output logic            end_of_text
);

    logic [2:0]  idx_reg;
    logic        valid_reg, valid_next;
    logic [23:0] cp_reg;
    logic [2:0]  len_reg;
    logic        bad_reg, eor_reg, eot_reg;

    logic        load;
    logic        in_err;
    logic        is_final;
    logic [2:0]  idx_inc;

    assign idx_inc  = idx_reg + 3'd1;
    assign in_err   = idx_reg < head_item.err_cnt;
    assign is_final = head_item.tail ? (idx_reg == head_item.err_cnt)
                                     : (idx_inc == head_item.err_cnt);
    assign load     = head_valid && (!valid_reg || !out_stall);
    assign pop      = load && is_final;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cp_reg  <= in_err ? {16'd0, utf8d_pkg::QMARK} : head_item.tail_cp;
            len_reg <= in_err ? utf8d_pkg::LEN1 : head_item.tail_len;
            bad_reg <= in_err ? 1'b1 : head_item.tail_bad;
            eor_reg <= is_final;
            eot_reg <= is_final && head_item.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
            begin
                idx_reg <= is_final ? 3'd0 : idx_inc;
            end
        end
    end

    assign out_valid   = valid_reg;
    assign code_point  = cp_reg;
    assign byte_length = len_reg;
    assign malformed   = bad_reg;
    assign end_of_run  = eor_reg;
    assign end_of_text = eot_reg;

endmodule

/* design/utf8_checked_decoder.sv */
// Top level of the UTF-8 checked decoder: front, descriptor queue and back.
// Depends on utf8d_pkg, utf8d_front, utf8d_queue, utf8d_back.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  input   | in_valid / in_stall | data_byte[7:0], last_byte
//  output  | out_valid/out_stall | code_point[23:0], byte_length[2:0],
//          |                     | malformed, end_of_run, end_of_text
//
// One byte is taken per cycle while the queue has room; a byte that causes
// k results (k up to 5) holds the back end until all are loaded, so error
// bursts drain at one result per cycle while out_stall is low. Each result
// passes a QUEUE_DEPTH-entry queue slot, then the output register.
// Reset clears the open sequence, the queue and the output valid flag.
// in_stall rises only when the queue is full; out_stall holds the output.
module utf8_checked_decoder #(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] code_point,
    output logic [2:0]  byte_length,
    output logic        malformed,
    output logic        end_of_run,
    output logic        end_of_text
);

    logic            push, full, pop, head_valid;
    utf8d_pkg::run_t push_item, head_item;

    utf8d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    utf8d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    utf8d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_item   (head_item),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_point  (code_point),
        .byte_length (byte_length),
        .malformed   (malformed),
        .end_of_run  (end_of_run),
        .end_of_text (end_of_text)
    );

endmodule

/* design/utf8d_checker.sv */
// Port-level checks for utf8_checked_decoder, bound to the top level.
// Depends only on the top level's ports.
module utf8d_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  data_byte,
    input logic        last_byte,
    input logic        out_valid,
    input logic        out_stall,
    input logic [23:0] code_point,
    input logic [2:0]  byte_length,
    input logic        malformed,
    input logic        end_of_run,
    input logic        end_of_text
);

    // malformed items are always a one-byte '?'
    a_bad_is_qmark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && malformed |-> code_point == 24'h3F && byte_length == 3'd1)
        else $error("malformed item not a one-byte '?'");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> byte_length != 3'd0 && byte_length <= 3'd5)
        else $error("byte_length out of range");

    a_eot_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_text |-> end_of_run)
        else $error("end_of_text without end_of_run");

    // a valid one-byte character is plain ASCII
    a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !malformed && byte_length == 3'd1 |-> code_point <= 24'h7F)
        else $error("valid one-byte item above 0x7F");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(code_point)
                                   && $stable(byte_length) && $stable(end_of_run))
        else $error("stalled output item changed");

endmodule

bind utf8_checked_decoder utf8d_checker u_utf8d_checker (.*);
